FILE: design/char_stream_tokenizer_defines.svh
// Assertion helpers used by the tokenizer back end (csttok_back).
`ifndef CHAR_STREAM_TOKENIZER_DEFINES_SVH
`define CHAR_STREAM_TOKENIZER_DEFINES_SVH

`define CST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define CST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/csttok_pkg.sv
package csttok_pkg;

  localparam int MAX_LINE = 2048;
  localparam int COL_W = 11;
  localparam logic [COL_W-1:0] COL_MAX =
    COL_W'((MAX_LINE - 1 > 2047) ? 2047 : MAX_LINE - 1);
  localparam logic [10:0] LEN_MAX = 11'd2047;
  localparam int NSLOT = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_DASH
  } scan_mode_t;

  typedef enum logic [3:0] {
    KIND_UNKNOWN = 4'd0,
    KIND_RETURN  = 4'd1,
    KIND_TYPE    = 4'd2,
    KIND_IDENT   = 4'd3,
    KIND_NUMBER  = 4'd4,
    KIND_LPAREN  = 4'd5,
    KIND_RPAREN  = 4'd6,
    KIND_LBRACE  = 4'd7,
    KIND_RBRACE  = 4'd8,
    KIND_SEMI    = 4'd9,
    KIND_ARROW   = 4'd10
  } token_kind_t;

  typedef struct packed {
    token_kind_t       kind;
    logic [COL_W-1:0]  col;
    logic [10:0]       len;
    logic [7:0]        fc;
  } token_t;

  typedef struct packed {
    logic [NSLOT-1:0]  mask;
    logic [31:0]       line;
    token_t [NSLOT-1:0] tok;
  } bundle_t;

  function automatic logic [7:0] kw_return_char(input logic [2:0] i);
    logic [7:0] ch;
    case (i)
      3'd0: ch = "r";
      3'd1: ch = "e";
      3'd2: ch = "t";
      3'd3: ch = "u";
      3'd4: ch = "r";
      3'd5: ch = "n";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] kw_type_char(input logic [2:0] i);
    logic [7:0] ch;
    case (i)
      3'd0: ch = "u";
      3'd1: ch = "i";
      3'd2: ch = "n";
      3'd3: ch = "t";
      3'd4: ch = "8";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic token_t pending_token(
    input scan_mode_t       mode,
    input logic [COL_W-1:0] start,
    input logic [10:0]      len,
    input logic             kwr,
    input logic             kwt,
    input logic [7:0]       fc
  );
    token_t t;
    t.col = start;
    t.len = len;
    t.fc = fc;
    t.kind = KIND_UNKNOWN;
    case (mode)
      MODE_IDENT: begin
        if (kwr && len == 11'd6) begin
          t.kind = KIND_RETURN;
        end else if (kwt && len == 11'd5) begin
          t.kind = KIND_TYPE;
        end else begin
          t.kind = KIND_IDENT;
        end
      end
      MODE_NUMBER: t.kind = KIND_NUMBER;
      MODE_DASH: begin
        t.kind = KIND_UNKNOWN;
        t.len = 11'd1;
        t.fc = CH_DASH;
      end
      default: t.kind = KIND_UNKNOWN;
    endcase
    return t;
  endfunction

endpackage

FILE: design/csttok_front.sv
module csttok_front
  import csttok_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  char_code,
  input  logic        line_end,
  input  logic [31:0] src_line,
  output logic        push,
  output bundle_t     bundle
);

  scan_mode_t       mode_r, mode_nxt, mode_a;
  logic [COL_W-1:0] column_r, column_nxt;
  logic [COL_W-1:0] start_r, start_nxt;
  logic [10:0]      len_r, len_nxt;
  logic             kwr_r, kwr_nxt, kwt_r, kwt_nxt;
  logic [7:0]       pfc_r, pfc_nxt;

  logic is_alpha, is_digit, is_blank;
  logic do_arrow, do_flush, do_single;
  token_kind_t single_kind;

  assign is_alpha = (char_code inside {[8'h61:8'h7A], [8'h41:8'h5A]});
  assign is_digit = (char_code inside {[8'h30:8'h39]});
  assign is_blank = (char_code inside {CH_SPACE, CH_TAB, CH_LF, CH_NUL});

  // Scan state after this character, before the end-of-line flush.
  always_comb begin
    mode_a = mode_r;
    start_nxt = start_r;
    len_nxt = len_r;
    kwr_nxt = kwr_r;
    kwt_nxt = kwt_r;
    pfc_nxt = pfc_r;
    do_arrow = 1'b0;
    do_flush = 1'b0;
    do_single = 1'b0;
    if ((mode_r == MODE_IDENT && (is_alpha || is_digit)) ||
        (mode_r == MODE_NUMBER && is_digit)) begin
      kwr_nxt = kwr_r && (len_r < 11'd6) && (char_code == kw_return_char(len_r[2:0]));
      kwt_nxt = kwt_r && (len_r < 11'd5) && (char_code == kw_type_char(len_r[2:0]));
      if (len_r < LEN_MAX) begin
        len_nxt = len_r + 11'd1;
      end
    end else if (mode_r == MODE_DASH && char_code == CH_GT) begin
      do_arrow = 1'b1;
      mode_a = MODE_IDLE;
    end else begin
      do_flush = (mode_r != MODE_IDLE);
      mode_a = MODE_IDLE;
      if (is_alpha || is_digit || char_code == CH_DASH) begin
        mode_a = is_alpha ? MODE_IDENT : (is_digit ? MODE_NUMBER : MODE_DASH);
        start_nxt = column_r;
        len_nxt = 11'd1;
        pfc_nxt = char_code;
        kwr_nxt = is_alpha && (char_code == kw_return_char(3'd0));
        kwt_nxt = is_alpha && (char_code == kw_type_char(3'd0));
      end else if (!is_blank) begin
        do_single = 1'b1;
      end
    end
    mode_nxt = line_end ? MODE_IDLE : mode_a;
    if (line_end) begin
      column_nxt = '0;
    end else if (column_r < COL_MAX) begin
      column_nxt = column_r + COL_W'(1);
    end else begin
      column_nxt = column_r;
    end
  end

  always_comb begin
    case (char_code)
      CH_LPAREN: single_kind = KIND_LPAREN;
      CH_RPAREN: single_kind = KIND_RPAREN;
      CH_LBRACE: single_kind = KIND_LBRACE;
      CH_RBRACE: single_kind = KIND_RBRACE;
      CH_SEMI:   single_kind = KIND_SEMI;
      default:   single_kind = KIND_UNKNOWN;
    endcase
  end

  // Token slots in emission order: pending or arrow, single character, line flush.
  always_comb begin
    bundle.line = src_line;
    if (do_arrow) begin
      bundle.tok[0].kind = KIND_ARROW;
      bundle.tok[0].col = start_r;
      bundle.tok[0].len = 11'd2;
      bundle.tok[0].fc = CH_DASH;
    end else begin
      bundle.tok[0] = pending_token(mode_r, start_r, len_r, kwr_r, kwt_r, pfc_r);
    end
    bundle.tok[1].kind = single_kind;
    bundle.tok[1].col = column_r;
    bundle.tok[1].len = 11'd1;
    bundle.tok[1].fc = char_code;
    bundle.tok[2] = pending_token(mode_a, start_nxt, len_nxt, kwr_nxt, kwt_nxt, pfc_nxt);
    bundle.mask = {line_end && (mode_a != MODE_IDLE), do_single, do_arrow || do_flush};
  end

  assign push = accept && (bundle.mask != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      column_r <= '0;
      start_r <= '0;
      len_r <= '0;
      kwr_r <= 1'b0;
      kwt_r <= 1'b0;
      pfc_r <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      column_r <= column_nxt;
      start_r <= start_nxt;
      len_r <= len_nxt;
      kwr_r <= kwr_nxt;
      kwt_r <= kwt_nxt;
      pfc_r <= pfc_nxt;
    end
  end

endmodule

FILE: design/csttok_queue.sv
module csttok_queue
  import csttok_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t wdata,
  output logic    full,
  input  logic    pop,
  output bundle_t rdata,
  output logic    head_valid
);

  bundle_t           entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign rdata = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

FILE: design/csttok_back.sv
`include "char_stream_tokenizer_defines.svh"

module csttok_back
  import csttok_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  bundle_t     head,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  output logic [3:0]  out_tuser,
  output logic        out_tlast
);

  logic [NSLOT-1:0] done_r, done_nxt, rem, pick;
  logic             load, last;
  logic             valid_r;
  token_t           tok_r, tok_sel;
  logic [31:0]      line_r;
  logic             last_r;

  assign rem = head.mask & ~done_r;
  assign pick = rem & (~rem + NSLOT'(1));
  assign last = ((rem & ~pick) == '0);
  assign load = head_valid && (!valid_r || out_tready);
  assign pop = load && last;

  always_comb begin
    tok_sel = head.tok[0];
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (pick[i]) begin
        tok_sel = head.tok[i];
      end
    end
    done_nxt = done_r;
    if (load) begin
      done_nxt = last ? '0 : (done_r | pick);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      done_r <= '0;
    end else begin
      done_r <= done_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r <= tok_sel;
      line_r <= head.line;
      last_r <= last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata = {2'b00, tok_r.fc, tok_r.len, tok_r.col, line_r};
  assign out_tuser = tok_r.kind;
  assign out_tlast = last_r;

  `CST_ASSERT_NOW(a_pop_has_head, pop, head_valid, "queue popped while empty")
  `CST_ASSERT_NOW(a_done_in_mask, head_valid, (done_r & ~head.mask) == '0,
                  "served slot outside the word's token mask")
  `CST_ASSERT_NEXT(a_pop_clears, pop, done_r == '0, "slot record not cleared after pop")

endmodule

FILE: design/char_stream_tokenizer.sv
// Streaming tokenizer: one source byte enters per word on the input side, with its line
// number and an end-of-line mark (in_tlast), and tokens leave on the output side with
// the token kind in out_tuser and out_tlast set on the last token caused by an input word.
// The scanner takes one byte per cycle while the queue has room; a byte that causes
// several tokens (at most three) sends them out one after another, and a two-entry token
// queue between scanner and output lets the scanner keep accepting bytes while those
// tokens drain. Bytes that cause no token cost nothing at the output. Sustained rate is
// one byte per cycle when each byte causes at most one token and out_tready stays high.
module char_stream_tokenizer
  import csttok_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // char_code[7:0], src_line[39:8]
  input  logic        in_tlast,   // line_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // token_line[31:0], start_column[42:32],
                                  // token_length[53:43], first_char[61:54], zero[63:62]
  output logic [3:0]  out_tuser,  // token_kind[3:0]
  output logic        out_tlast   // last_of_run
);

  logic    accept, push, full, pop, head_valid;
  bundle_t push_data, head_data;

  assign in_tready = !full;
  assign accept = in_tvalid && in_tready;

  csttok_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .char_code   (in_tdata[7:0]),
    .line_end    (in_tlast),
    .src_line    (in_tdata[39:8]),
    .push        (push),
    .bundle      (push_data)
  );

  csttok_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .wdata      (push_data),
    .full       (full),
    .pop        (pop),
    .rdata      (head_data),
    .head_valid (head_valid)
  );

  csttok_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: tb/sv/char_stream_tokenizer_check.sv
`default_nettype none

module char_stream_tokenizer_check
  import csttok_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [39:0] in_tdata,   // char_code[7:0], src_line[39:8]
  input  wire logic        in_tlast,   // line_end
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [63:0] out_tdata,  // token_line[31:0], start_column[42:32],
                                       // token_length[53:43], first_char[61:54], zero[63:62]
  input  wire logic [3:0]  out_tuser,  // token_kind[3:0]
  input  wire logic        out_tlast,  // last_of_run
  output int               fail_count,
  output int               due_count
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [47:0] RETURN_WORD = "return";
  localparam logic [39:0] TYPE_WORD   = "uint8";

  typedef struct packed {
    logic              last;
    token_kind_t       kind;
    logic [1:0]        pad;
    logic [7:0]        fc;
    logic [10:0]       len;
    logic [COL_W-1:0]  col;
    logic [31:0]       line;
  } token_word_t;

  token_word_t tokens_due[$];
  token_word_t burst[$];

  scan_mode_t       mode;
  logic [COL_W-1:0] col_count;
  logic [COL_W-1:0] tok_start;
  logic [10:0]      run_len;
  logic             ret_hit;
  logic             typ_hit;
  logic [7:0]       first_ch;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic emit(input token_kind_t kind, input logic [31:0] line,
                      input logic [COL_W-1:0] col, input logic [10:0] len,
                      input logic [7:0] fc);
    token_word_t t;
    t.last = 1'b0;
    t.kind = kind;
    t.pad = 2'b00;
    t.fc = fc;
    t.len = len;
    t.col = col;
    t.line = line;
    burst.push_back(t);
  endtask

  task automatic close_run(input logic [31:0] line);
    case (mode)
      MODE_IDENT: begin
        if (ret_hit && run_len == 11'd6) begin
          emit(KIND_RETURN, line, tok_start, run_len, first_ch);
        end else if (typ_hit && run_len == 11'd5) begin
          emit(KIND_TYPE, line, tok_start, run_len, first_ch);
        end else begin
          emit(KIND_IDENT, line, tok_start, run_len, first_ch);
        end
      end
      MODE_NUMBER: emit(KIND_NUMBER, line, tok_start, run_len, first_ch);
      MODE_DASH:   emit(KIND_UNKNOWN, line, tok_start, 11'd1, CH_DASH);
      default: begin
      end
    endcase
    mode = MODE_IDLE;
  endtask

  task automatic open_run(input scan_mode_t m, input logic [COL_W-1:0] col,
                          input logic [7:0] c);
    mode = m;
    tok_start = col;
    run_len = 11'd1;
    first_ch = c;
    ret_hit = (m == MODE_IDENT) && (c == RETURN_WORD[47:40]);
    typ_hit = (m == MODE_IDENT) && (c == TYPE_WORD[39:32]);
  endtask

  task automatic grow_run(input logic [7:0] c);
    if (run_len < 11'd6) begin
      ret_hit = ret_hit && (c == RETURN_WORD[8*(5-run_len) +: 8]);
    end else begin
      ret_hit = 1'b0;
    end
    if (run_len < 11'd5) begin
      typ_hit = typ_hit && (c == TYPE_WORD[8*(4-run_len) +: 8]);
    end else begin
      typ_hit = 1'b0;
    end
    if (run_len < LEN_MAX) begin
      run_len = run_len + 11'd1;
    end
  endtask

  task automatic scan_char(input logic [7:0] c, input logic eol, input logic [31:0] line);
    logic [COL_W-1:0] col;
    token_kind_t      kind;
    col = col_count;
    burst.delete();
    if (mode == MODE_IDENT && (is_letter(c) || is_digit(c))) begin
      grow_run(c);
    end else if (mode == MODE_NUMBER && is_digit(c)) begin
      grow_run(c);
    end else if (mode == MODE_DASH && c == CH_GT) begin
      emit(KIND_ARROW, line, tok_start, 11'd2, CH_DASH);
      mode = MODE_IDLE;
    end else begin
      close_run(line);
      if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_NUL) begin
      end else if (is_letter(c)) begin
        open_run(MODE_IDENT, col, c);
      end else if (is_digit(c)) begin
        open_run(MODE_NUMBER, col, c);
      end else if (c == CH_DASH) begin
        open_run(MODE_DASH, col, c);
      end else begin
        case (c)
          CH_LPAREN: kind = KIND_LPAREN;
          CH_RPAREN: kind = KIND_RPAREN;
          CH_LBRACE: kind = KIND_LBRACE;
          CH_RBRACE: kind = KIND_RBRACE;
          CH_SEMI:   kind = KIND_SEMI;
          default:   kind = KIND_UNKNOWN;
        endcase
        emit(kind, line, col, 11'd1, c);
      end
    end
    if (eol) begin
      close_run(line);
      col_count = '0;
    end else if (col_count < COL_MAX) begin
      col_count = col_count + COL_W'(1);
    end
    if (burst.size() > 0) begin
      burst[burst.size()-1].last = 1'b1;
    end
    foreach (burst[i]) begin
      tokens_due.push_back(burst[i]);
    end
  endtask

  task automatic check_token();
    token_word_t got;
    token_word_t exp;
    got.last = out_tlast;
    got.kind = token_kind_t'(out_tuser);
    got.pad = out_tdata[63:62];
    got.fc = out_tdata[61:54];
    got.len = out_tdata[53:43];
    got.col = out_tdata[42:32];
    got.line = out_tdata[31:0];
    if (tokens_due.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected token word: kind %0d line %h col %0d len %0d fc %h last %b",
               $time, got.kind, got.line, got.col, got.len, got.fc, got.last);
    end else begin
      exp = tokens_due.pop_front();
      if (got !== exp) begin
        fail_count++;
        $display("%0t: token mismatch: expected kind %0d line %h col %0d len %0d fc %h last %b pad %b",
                 $time, exp.kind, exp.line, exp.col, exp.len, exp.fc, exp.last, exp.pad);
        $display("%0t:                   actual kind %0d line %h col %0d len %0d fc %h last %b pad %b",
                 $time, got.kind, got.line, got.col, got.len, got.fc, got.last, got.pad);
      end
    end
  endtask

  initial begin
    fail_count = 0;
    due_count = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      mode = MODE_IDLE;
      col_count = '0;
      tok_start = '0;
      run_len = '0;
      ret_hit = 1'b0;
      typ_hit = 1'b0;
      first_ch = '0;
      tokens_due.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        scan_char(in_tdata[7:0], in_tlast, in_tdata[39:8]);
      end
      if (out_tvalid && out_tready) begin
        check_token();
      end
    end
    due_count = tokens_due.size();
  end

endmodule

`default_nettype wire

FILE: tb/sv/char_stream_tokenizer_tb.sv
`default_nettype none

module char_stream_tokenizer_tb
  import csttok_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // char_code[7:0], src_line[39:8]
  logic        in_tlast = 1'b0; // line_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // token_line[31:0], start_column[42:32],
                                // token_length[53:43], first_char[61:54], zero[63:62]
  logic [3:0]  out_tuser;       // token_kind[3:0]
  logic        out_tlast;       // last_of_run

  int fail_count;
  int due_count;
  int send_idle = 0;
  int recv_stall = 0;
  int items_sent = 0;

  logic [31:0] cur_line;
  logic [7:0]  frag[$];

  always #1 clk = ~clk;

  char_stream_tokenizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  char_stream_tokenizer_check check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic set_phase(input int p);
    case (p)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 57; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 57; end
      default: begin send_idle = 15; recv_stall = 15; end
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_char(input logic [7:0] c, input logic eol, input logic [31:0] ln);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ln, c};
    in_tlast <= eol;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input logic eol, input logic [31:0] ln);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], eol && (i == s.len() - 1), ln);
    end
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(1) == 0) begin
      return 8'("a" + $urandom_range(25));
    end
    return 8'("A" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  task automatic push_word(input string w);
    for (int i = 0; i < w.len(); i++) begin
      frag.push_back(w[i]);
    end
  endtask

  task automatic build_fragment();
    int    r;
    int    n;
    string w;
    frag.delete();
    r = $urandom_range(99);
    if (r < 10) begin
      push_word("return");
    end else if (r < 18) begin
      push_word("uint8");
    end else if (r < 26) begin
      case ($urandom_range(5))
        0: w = "retur";
        1: w = "uint";
        2: w = "returnx";
        3: w = "uint88";
        4: w = "Return";
        default: w = "uinT8";
      endcase
      push_word(w);
    end else if (r < 40) begin
      n = $urandom_range(6);
      frag.push_back(rand_letter());
      for (int i = 0; i < n; i++) begin
        frag.push_back(($urandom_range(2) == 0) ? rand_digit() : rand_letter());
      end
    end else if (r < 52) begin
      n = $urandom_range(5, 1);
      for (int i = 0; i < n; i++) begin
        frag.push_back(rand_digit());
      end
    end else if (r < 66) begin
      case ($urandom_range(4))
        0: frag.push_back(CH_LPAREN);
        1: frag.push_back(CH_RPAREN);
        2: frag.push_back(CH_LBRACE);
        3: frag.push_back(CH_RBRACE);
        default: frag.push_back(CH_SEMI);
      endcase
    end else if (r < 72) begin
      frag.push_back(CH_DASH);
      frag.push_back(CH_GT);
    end else if (r < 76) begin
      frag.push_back(CH_DASH);
    end else if (r < 88) begin
      case ($urandom_range(3))
        0: frag.push_back(CH_SPACE);
        1: frag.push_back(CH_TAB);
        2: frag.push_back(CH_LF);
        default: frag.push_back(CH_NUL);
      endcase
    end else begin
      frag.push_back(8'($urandom_range(255)));
    end
  endtask

  initial begin
    logic eol;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_phase(0);
    send_text("return uint8(", 1'b0, 32'h0000_0000);
    send_text("-;->{}", 1'b1, 32'hFFFF_FFFF);
    send_char(CH_NUL, 1'b0, 32'd7);
    send_char(CH_TAB, 1'b0, 32'd7);
    send_char(8'hFF, 1'b0, 32'd7);
    send_char("7", 1'b0, 32'd7);
    // The number is still pending when the line number moves on.
    send_char("x", 1'b1, 32'd8);
    send_char("-", 1'b1, 32'd9);

    cur_line = 32'd11;
    while (items_sent < 350) begin
      set_phase((items_sent / 40) % 4);
      build_fragment();
      eol = ($urandom_range(99) < 15);
      foreach (frag[i]) begin
        send_char(frag[i], eol && (i == frag.size() - 1), cur_line);
      end
      if (eol) begin
        cur_line = ($urandom_range(19) == 0) ? 32'($urandom()) : cur_line + 32'd1;
      end else if ($urandom_range(99) < 3) begin
        cur_line = cur_line + 32'd1;
      end
    end
    in_tvalid <= 1'b0;

    while (due_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("char_stream_tokenizer_tb: clean");
    end else begin
      $display("char_stream_tokenizer_tb: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("char_stream_tokenizer_tb: errors");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+design
design/csttok_pkg.sv
design/csttok_front.sv
design/csttok_queue.sv
design/csttok_back.sv
design/char_stream_tokenizer.sv
tb/sv/char_stream_tokenizer_check.sv
tb/sv/char_stream_tokenizer_tb.sv
